### rtl/core/complex_field_colorizer_assert.svh
// Assertion macros for the complex field colorizer.
// Included by the top level; no other dependencies.
`ifndef COMPLEX_FIELD_COLORIZER_ASSERT_SVH
`define COMPLEX_FIELD_COLORIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CFC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cfc_pkg.sv
// Shared constants and tables for the complex field colorizer.
// No dependencies.
`default_nettype none
package cfc_pkg;

    localparam int          CORDIC_STEPS = 14;
    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [15:0] DIV10_MUL    = 16'd52429;
    localparam int          DIV10_SHIFT  = 19;

    localparam logic [2:0] VIEW_REAL  = 3'd0;
    localparam logic [2:0] VIEW_IMAG  = 3'd1;
    localparam logic [2:0] VIEW_MAG   = 3'd2;
    localparam logic [2:0] VIEW_PHASE = 3'd3;

    localparam logic [1:0] REG_VIEW_MODE      = 2'd0;
    localparam logic [1:0] REG_NORMALIZE_VIEW = 2'd1;
    localparam logic [1:0] REG_SHOW_POTENTIAL = 2'd2;

    // Arctangent of 2^-i in 2^-16 turns, rounded.
    function automatic logic [13:0] atan_turn(input logic [3:0] idx);
        logic [13:0] res;
        case (idx)
            4'd0:    res = 14'd8192;
            4'd1:    res = 14'd4836;
            4'd2:    res = 14'd2555;
            4'd3:    res = 14'd1297;
            4'd4:    res = 14'd651;
            4'd5:    res = 14'd326;
            4'd6:    res = 14'd163;
            4'd7:    res = 14'd81;
            4'd8:    res = 14'd41;
            4'd9:    res = 14'd20;
            4'd10:   res = 14'd10;
            4'd11:   res = 14'd5;
            4'd12:   res = 14'd3;
            4'd13:   res = 14'd1;
            default: res = 14'd0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/core/cfc_sqrt.sv
// Iterative integer square root of a^2 + b^2, one result bit per cycle.
// Uses no package; squares are formed in PH_SQA then PH_SQB with one multiplier.
`default_nettype none
module cfc_sqrt #(
    parameter int S = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [S-1:0] i_a,
    input  wire logic [S-1:0] i_b,
    output logic              o_busy,
    output logic [S-1:0]      o_root
);
    localparam int NB = 2 * S;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQA  = 2'd1;
    localparam logic [1:0] PH_SQB  = 2'd2;
    localparam logic [1:0] PH_RUN  = 2'd3;

    logic [1:0]    r_phase;
    logic [S-1:0]  r_a, r_b;
    logic [NB-1:0] r_n, r_res, r_bit;
    logic [S-1:0]  w_op;
    logic [NB-1:0] w_prod, w_sum;

    assign w_op   = (r_phase == PH_SQA) ? r_a : r_b;
    assign w_prod = w_op * w_op;
    assign w_sum  = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_phase <= PH_SQA;
                    end
                end
                PH_SQA: begin
                    r_n     <= w_prod;
                    r_phase <= PH_SQB;
                end
                PH_SQB: begin
                    r_n     <= r_n + w_prod;
                    r_res   <= '0;
                    r_bit   <= NB'(1) << (NB - 2);
                    r_phase <= PH_RUN;
                end
                PH_RUN: begin
                    if (r_n >= w_sum) begin
                        r_n   <= r_n - w_sum;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_phase <= PH_IDLE;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_busy = (r_phase != PH_IDLE);
    assign o_root = r_res[S-1:0];
endmodule
`default_nettype wire

### rtl/core/cfc_cordic.sv
// Vectoring CORDIC giving the phase of (re, im) as a hue in 2^-16 turns.
// Uses cfc_pkg for the step count and arctangent table.
`default_nettype none
module cfc_cordic #(
    parameter int S = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [S-1:0] i_re,
    input  wire logic signed [S-1:0] i_im,
    output logic                     o_busy,
    output logic [15:0]              o_hue
);
    localparam int W = S + 10;

    logic                r_busy;
    logic [3:0]          r_i;
    logic signed [W-1:0] r_x, r_y;
    logic signed [17:0]  r_ang;
    logic signed [W-1:0] w_x0, w_y0, w_dx, w_dy;
    logic signed [17:0]  w_atan, w_h;

    assign w_x0   = W'(i_re) <<< 8;
    assign w_y0   = W'(i_im) <<< 8;
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_atan = $signed({4'b0, cfc_pkg::atan_turn(r_i)});
    assign w_h    = r_ang + 18'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            // Fold the left half plane over by a half turn.
            if (w_x0 < 0) begin
                r_x   <= -w_x0;
                r_y   <= -w_y0;
                r_ang <= 18'sd32768;
            end else begin
                r_x   <= w_x0;
                r_y   <= w_y0;
                r_ang <= '0;
            end
            r_i    <= '0;
            r_busy <= (i_im != '0);
        end else if (r_busy) begin
            if (!r_y[W-1]) begin
                r_x   <= r_x + w_dx;
                r_y   <= r_y - w_dy;
                r_ang <= r_ang + w_atan;
            end else begin
                r_x   <= r_x - w_dx;
                r_y   <= r_y + w_dy;
                r_ang <= r_ang - w_atan;
            end
            r_i <= r_i + 4'd1;
            if (r_i == 4'(cfc_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_hue  = w_h[15:0];
endmodule
`default_nettype wire

### rtl/core/cfc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
`default_nettype none
module cfc_div #(
    parameter int NW = 34,
    parameter int DW = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num, r_quo;
    logic [DW-1:0] r_den;
    logic [DW:0]   r_rem;
    logic [DW:0]   w_trial, w_diff;
    logic          w_ge;

    assign w_trial = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_trial;
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_num <= r_num << 1;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

### rtl/core/complex_field_colorizer.sv
// Complex field colorizer: one word in, at most one RGB word out. A measure word (tuser bit 0
// low) is paced by the bit-serial square root. A render word adds one divide, with NW =
// max(SAMPLE_BITS + 18, FRAC_BITS + 6) quotient bits (34 by default), a second divide when
// the potential tint is on, and hue mixing in ST_HUE and ST_MIX. A render word also holds
// in ST_MIX while the output register still carries an unread word. The CORDIC runs beside
// the square root and never sets the pace. s_axis_tready is high only between words; a
// finished result sits in the output register while the next word is taken.
`default_nettype none
`include "complex_field_colorizer_assert.svh"
module complex_field_colorizer #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 13
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // psi_re, psi_im, pot_re from bit 0 up, zero padded to whole bytes
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // op, frame_start from bit 0 up
    input  wire logic [1:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // red, green, blue from bit 0 up
    output logic [23:0]                              m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [1:0]                          i_cfg_idx,
    input  wire logic [2:0]                          i_cfg_data
);
    localparam int S  = SAMPLE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = (S > F + 5) ? S : F + 5;
    localparam int NW = (S + 18 > F + 6) ? S + 18 : F + 6;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAG  = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_DIV2 = 3'd3;
    localparam logic [2:0] ST_PVT  = 3'd4;
    localparam logic [2:0] ST_HUE  = 3'd5;
    localparam logic [2:0] ST_MIX  = 3'd6;

    function automatic logic [7:0] to_channel(input logic signed [19:0] t);
        logic [24:0] acc;
        logic [7:0]  res;
        acc = ({9'b0, t[15:0]} << 8) - {9'b0, t[15:0]} + 25'd32768;
        if (t <= 0) begin
            res = 8'd0;
        end else if (t >= 20'sd65536) begin
            res = 8'd255;
        end else begin
            res = acc[23:16];
        end
        return res;
    endfunction

    logic [2:0]   r_state;
    logic [2:0]   r_view;
    logic         r_norm, r_show;
    logic [S-1:0] r_peak_mag, r_peak_pot;
    logic         r_op, r_fs;
    logic [S-1:0] r_re, r_im, r_pot;
    logic [16:0]  r_q, r_v, r_mid;
    logic [14:0]  r_tint;
    logic [34:0]  r_pvm;
    logic [2:0]   r_sec;
    logic         r_m_valid;
    logic [23:0]  r_m_data;

    logic          w_accept;
    logic [S-1:0]  w_in_re, w_in_im, w_in_pot, w_in_abs_re, w_in_abs_im;
    logic [S-1:0]  w_abs_re, w_abs_im, w_abs_pot, w_part_abs;
    logic          w_sqrt_busy, w_cordic_busy, w_div_busy;
    logic [S-1:0]  w_root;
    logic [15:0]   w_hue;
    logic          w_div_start;
    logic [NW-1:0] w_div_num, w_div_quo;
    logic [DW-1:0] w_div_den, w_den1;
    logic [NW-1:0] w_num_main, w_num_pv;
    logic [DW-1:0] w_den_pv;
    logic [16:0]   w_qc, w_v, w_fm;
    logic [18:0]   w_pv3, w_h6;
    logic [34:0]   w_midp;
    logic          w_part_neg;
    logic signed [19:0] w_pr, w_r, w_g, w_b, w_hi, w_mid;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    assign w_in_re     = s_axis_tdata[S-1:0];
    assign w_in_im     = s_axis_tdata[2*S-1:S];
    assign w_in_pot    = s_axis_tdata[3*S-1:2*S];
    assign w_in_abs_re = w_in_re[S-1] ? (~w_in_re + 1'b1) : w_in_re;
    assign w_in_abs_im = w_in_im[S-1] ? (~w_in_im + 1'b1) : w_in_im;
    assign w_abs_re    = r_re[S-1] ? (~r_re + 1'b1) : r_re;
    assign w_abs_im    = r_im[S-1] ? (~r_im + 1'b1) : r_im;
    assign w_abs_pot   = r_pot[S-1] ? (~r_pot + 1'b1) : r_pot;

    cfc_sqrt #(.S(S)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_a     (w_in_abs_re),
        .i_b     (w_in_abs_im),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    cfc_cordic #(.S(S)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_re    ($signed(w_in_re)),
        .i_im    ($signed(w_in_im)),
        .o_busy  (w_cordic_busy),
        .o_hue   (w_hue)
    );

    // Main divide: brightness or real/imaginary ratio over the view divisor.
    assign w_den1     = r_norm ? DW'(r_peak_mag) : (DW'(1) << F);
    assign w_part_abs = (r_view == cfc_pkg::VIEW_REAL) ? w_abs_re : w_abs_im;
    assign w_part_neg = (r_view == cfc_pkg::VIEW_REAL) ? r_re[S-1] : r_im[S-1];
    assign w_num_main = ((r_view == cfc_pkg::VIEW_REAL) || (r_view == cfc_pkg::VIEW_IMAG))
                      ? ((NW'(w_part_abs) << 15) + NW'(w_den1 >> 1))
                      : ((NW'(w_root) << 16) + NW'(w_den1 >> 1));

    // Potential divide: |pot| over 0.8 * peak, or over 20.0 with no peak.
    assign w_num_pv = (r_peak_pot != '0)
                    ? ((NW'(w_abs_pot) << 16) + (NW'(w_abs_pot) << 14) + NW'(r_peak_pot >> 1))
                    : ((NW'(w_abs_pot) << 16) + (NW'(10) << F));
    assign w_den_pv = (r_peak_pot != '0) ? DW'(r_peak_pot) : (DW'(20) << F);

    assign w_div_start = ((r_state == ST_MAG) && !w_sqrt_busy && r_op)
                      || ((r_state == ST_DIV1) && !w_div_busy && r_show);
    assign w_div_num   = (r_state == ST_MAG) ? w_num_main : w_num_pv;
    assign w_div_den   = (r_state == ST_MAG) ? w_den1 : w_den_pv;

    cfc_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_div_quo)
    );

    assign w_qc  = (w_div_quo > NW'(cfc_pkg::ONE_Q16)) ? cfc_pkg::ONE_Q16 : w_div_quo[16:0];
    assign w_pv3 = {2'b0, w_qc} + {1'b0, w_qc, 1'b0} + 19'd5;

    // Hue sector and fraction; the middle channel rises or falls with the fraction.
    assign w_h6  = ({3'b0, w_hue} << 2) + ({3'b0, w_hue} << 1);
    assign w_v   = ((r_view == cfc_pkg::VIEW_PHASE) && r_norm) ? cfc_pkg::ONE_Q16 : r_q;
    assign w_fm  = w_h6[16] ? (cfc_pkg::ONE_Q16 - {1'b0, w_h6[15:0]}) : {1'b0, w_h6[15:0]};
    assign w_midp = ({18'b0, w_v} * {18'b0, w_fm}) + 35'd32768;

    assign w_pr  = w_part_neg ? (20'sd32768 - $signed({3'b0, r_q}))
                              : (20'sd32768 + $signed({3'b0, r_q}));
    assign w_hi  = $signed({3'b0, r_v});
    assign w_mid = $signed({3'b0, r_mid});

    always_comb begin
        case (r_view)
            cfc_pkg::VIEW_REAL, cfc_pkg::VIEW_IMAG: begin
                w_r = w_pr;
                w_g = w_pr;
                w_b = w_pr;
            end
            cfc_pkg::VIEW_MAG: begin
                w_r = $signed({3'b0, r_q});
                w_g = $signed({3'b0, r_q});
                w_b = $signed({3'b0, r_q});
            end
            default: begin
                case (r_sec)
                    3'd0:    begin w_r = w_hi;  w_g = w_mid; w_b = '0;    end
                    3'd1:    begin w_r = w_mid; w_g = w_hi;  w_b = '0;    end
                    3'd2:    begin w_r = '0;    w_g = w_hi;  w_b = w_mid; end
                    3'd3:    begin w_r = '0;    w_g = w_mid; w_b = w_hi;  end
                    3'd4:    begin w_r = w_mid; w_g = '0;    w_b = w_hi;  end
                    default: begin w_r = w_hi;  w_g = '0;    w_b = w_mid; end
                endcase
            end
        endcase
        // Tint red for positive potential, blue for negative.
        if (!r_pot[S-1]) begin
            w_r = w_r + $signed({5'b0, r_tint});
        end else begin
            w_b = w_b + $signed({5'b0, r_tint});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view     <= '0;
            r_norm     <= 1'b0;
            r_show     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfc_pkg::REG_VIEW_MODE:      r_view <= i_cfg_data;
                cfc_pkg::REG_NORMALIZE_VIEW: r_norm <= i_cfg_data[0];
                cfc_pkg::REG_SHOW_POTENTIAL: r_show <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_peak_mag <= S'(1);
            r_peak_pot <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            // Drop the word once taken, unless a new one is loaded below.
            if (m_axis_tready && (r_state != ST_MIX)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op    <= s_axis_tuser[0];
                        r_fs    <= s_axis_tuser[1];
                        r_re    <= w_in_re;
                        r_im    <= w_in_im;
                        r_pot   <= w_in_pot;
                        r_state <= ST_MAG;
                    end
                end
                ST_MAG: begin
                    if (!w_sqrt_busy) begin
                        if (!r_op) begin
                            if (r_fs) begin
                                r_peak_mag <= (w_root == '0) ? S'(1) : w_root;
                                r_peak_pot <= w_abs_pot;
                            end else begin
                                if (w_root > r_peak_mag) r_peak_mag <= w_root;
                                if (w_abs_pot > r_peak_pot) r_peak_pot <= w_abs_pot;
                            end
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIV1;
                        end
                    end
                end
                ST_DIV1: begin
                    if (!w_div_busy) begin
                        r_q    <= w_qc;
                        r_tint <= '0;
                        r_state <= r_show ? ST_DIV2 : ST_HUE;
                    end
                end
                ST_DIV2: begin
                    if (!w_div_busy) begin
                        r_pvm   <= {16'b0, w_pv3} * {19'b0, cfc_pkg::DIV10_MUL};
                        r_state <= ST_PVT;
                    end
                end
                ST_PVT: begin
                    r_tint  <= r_pvm[cfc_pkg::DIV10_SHIFT+14:cfc_pkg::DIV10_SHIFT];
                    r_state <= ST_HUE;
                end
                ST_HUE: begin
                    if (!w_cordic_busy) begin
                        r_v     <= w_v;
                        r_sec   <= w_h6[18:16];
                        r_mid   <= w_midp[32:16];
                        r_state <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    // Hold until the output register is free.
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {to_channel(w_b), to_channel(w_g), to_channel(w_r)};
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `CFC_ASSERT_NOW(a_peak_floor, i_clk, i_rst_n, 1'b1, r_peak_mag != '0, "peak magnitude is zero")
    `CFC_ASSERT_NEXT(a_measure_silent, i_clk, i_rst_n, (r_state == ST_MAG) && !w_sqrt_busy && !r_op, (r_state == ST_IDLE) && !$rose(r_m_valid), "measure word produced a result")
    `CFC_ASSERT_NEXT(a_mix_holds, i_clk, i_rst_n, (r_state == ST_MIX) && r_m_valid && !m_axis_tready, r_state == ST_MIX, "result overwrote a pending word")
endmodule
`default_nettype wire
